/* src/cooking_timer_controller_macros.svh */
// Assertion macros for the timer controller.
`ifndef COOKING_TIMER_CONTROLLER_MACROS_SVH
`define COOKING_TIMER_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

// A condition that must hold at every clock edge outside reset.
`define CTC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("timer controller check failed");

// A consequence that must hold in the same cycle as its antecedent.
`define CTC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("timer controller check failed");

`else

`define CTC_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define CTC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/ctc_pkg.sv */
package ctc_pkg;

  typedef enum logic [2:0] {
    FUNC_KEY        = 3'd0,
    FUNC_START_REL  = 3'd1,
    FUNC_STOP_REL   = 3'd2,
    FUNC_STOP_HOLD  = 3'd3,
    FUNC_TICK       = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    PH_SELECT  = 2'd0,
    PH_SETTING = 2'd1,
    PH_ARMED   = 2'd2,
    PH_RUNNING = 2'd3
  } phase_e;

  localparam logic [7:0] KEY_MICRO_LO = 8'h6D;  // 'm'
  localparam logic [7:0] KEY_MICRO_UP = 8'h4D;  // 'M'
  localparam logic [7:0] KEY_GRILL_LO = 8'h67;  // 'g'
  localparam logic [7:0] KEY_GRILL_UP = 8'h47;  // 'G'
  localparam logic [7:0] KEY_TEN_SEC  = 8'h31;  // '1'
  localparam logic [7:0] KEY_ONE_MIN  = 8'h32;  // '2'
  localparam logic [7:0] KEY_HALF_HR  = 8'h33;  // '3'

  localparam logic [3:0] DIGIT_MAX     = 4'd9;
  localparam logic [3:0] SEC_TENS_MAX  = 4'd6;
  localparam logic [3:0] SEC_TENS_WRAP = 4'd5;
  localparam logic [3:0] HALF_HR_STEP  = 4'd3;

  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [2:0] sec_tens;
    logic [3:0] sec_ones;
    phase_e     phase;
    logic       cook_on;
    logic       grill_on;
  } timer_state_t;

  typedef struct packed {
    logic done;
    logic capped;
    logic maxed;
  } step_flags_t;

endpackage

/* src/cooking_timer_controller.sv */
// Cooking-timer controller. It takes at most one event per clock cycle and gives
// exactly one result per event: the event is captured in an input register, the
// timer state is updated by the digit logic as the event moves on and the result
// lands in an output register. A result that waits on out_stall_i does not hold
// up the input side until both registers are full, so the sustained rate is one
// event per cycle while out_stall_i stays low.
`include "cooking_timer_controller_macros.svh"

module cooking_timer_controller import ctc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] func_i,
  input  logic [7:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] minute_tens_o,
  output logic [3:0] minute_ones_o,
  output logic [2:0] second_tens_o,
  output logic [3:0] second_ones_o,
  output logic [1:0] phase_now_o,
  output logic       cook_lamp_o,
  output logic       grill_indicator_o,
  output logic       done_pulse_o,
  output logic       minutes_capped_o,
  output logic       max_reached_o
);

  logic         evt_valid_q;
  logic [2:0]   evt_func_q;
  logic [7:0]   evt_key_q;
  logic         res_valid_q;
  timer_state_t res_state_q;
  step_flags_t  res_flags_q;
  timer_state_t st_q;
  timer_state_t st_d;
  step_flags_t  flags_d;
  logic         in_take;
  logic         advance;

  // The event register drains whenever the result register is empty or being read.
  assign advance    = evt_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = evt_valid_q && res_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  ctc_step u_step (
    .cur_i      (st_q),
    .func_i     (evt_func_q),
    .key_code_i (evt_key_q),
    .nxt_o      (st_d),
    .flags_o    (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      st_q        <= '{phase: PH_SELECT, default: '0};
    end else begin
      if (in_take) begin
        evt_valid_q <= 1'b1;
      end else if (advance) begin
        evt_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      evt_func_q <= func_i;
      evt_key_q  <= key_code_i;
    end
    if (advance) begin
      res_state_q <= st_d;
      res_flags_q <= flags_d;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign minute_tens_o     = res_state_q.min_tens;
  assign minute_ones_o     = res_state_q.min_ones;
  assign second_tens_o     = res_state_q.sec_tens;
  assign second_ones_o     = res_state_q.sec_ones;
  assign phase_now_o       = res_state_q.phase;
  assign cook_lamp_o       = res_state_q.cook_on;
  assign grill_indicator_o = res_state_q.grill_on;
  assign done_pulse_o      = res_flags_q.done;
  assign minutes_capped_o  = res_flags_q.capped;
  assign max_reached_o     = res_flags_q.maxed;

  // Only one lamp is ever lit, and none in select phase.
  `CTC_ASSERT_ALWAYS(a_lamps_exclusive, clk_i, rst_ni, !(st_q.cook_on && st_q.grill_on))
  `CTC_ASSERT_IMPLIES(a_select_dark, clk_i, rst_ni, st_q.phase == PH_SELECT,
                      !st_q.cook_on && !st_q.grill_on)
  // Armed or running always has time left on the clock.
  `CTC_ASSERT_IMPLIES(a_armed_nonzero, clk_i, rst_ni,
                      st_q.phase == PH_ARMED || st_q.phase == PH_RUNNING,
                      (|{st_q.min_tens, st_q.min_ones, st_q.sec_tens, st_q.sec_ones}))
  `CTC_ASSERT_IMPLIES(a_done_clears, clk_i, rst_ni, out_valid_o && done_pulse_o,
                      phase_now_o == PH_SELECT && !cook_lamp_o && !grill_indicator_o &&
                      minute_tens_o == 4'd0 && second_ones_o == 4'd0)
  `CTC_ASSERT_IMPLIES(a_max_digits, clk_i, rst_ni, out_valid_o && max_reached_o,
                      minute_tens_o == DIGIT_MAX && minute_ones_o == DIGIT_MAX &&
                      second_tens_o == SEC_TENS_MAX[2:0])

endmodule

/* src/ctc_step.sv */
module ctc_step import ctc_pkg::*; (
  input  timer_state_t cur_i,
  input  logic [2:0]   func_i,
  input  logic [7:0]   key_code_i,
  output timer_state_t nxt_o,
  output step_flags_t  flags_o
);

  logic [3:0] d0, d1, d2, d3;
  logic       hold;
  logic       mode_micro;
  logic       mode_grill;
  logic       cur_nonzero;

  assign mode_micro  = (key_code_i == KEY_MICRO_LO) || (key_code_i == KEY_MICRO_UP);
  assign mode_grill  = (key_code_i == KEY_GRILL_LO) || (key_code_i == KEY_GRILL_UP);
  assign cur_nonzero = |{cur_i.min_tens, cur_i.min_ones, cur_i.sec_tens, cur_i.sec_ones};

  always_comb begin
    nxt_o   = cur_i;
    flags_o = '0;
    d0      = cur_i.min_tens;
    d1      = cur_i.min_ones;
    d2      = {1'b0, cur_i.sec_tens};
    d3      = cur_i.sec_ones;
    hold    = 1'b0;

    case (func_e'(func_i))
      FUNC_KEY: begin
        if (cur_i.phase != PH_RUNNING) begin
          if (cur_i.phase == PH_SELECT) begin
            if (mode_micro) begin
              nxt_o.cook_on = 1'b1;
              nxt_o.phase   = PH_SETTING;
            end else if (mode_grill) begin
              nxt_o.grill_on = 1'b1;
              nxt_o.phase    = PH_SETTING;
            end
          end else if (!(mode_micro || mode_grill)) begin
            if (key_code_i == KEY_TEN_SEC) begin
              d2 = d2 + 4'd1;
            end else if (key_code_i == KEY_ONE_MIN) begin
              d1 = d1 + 4'd1;
            end else if (key_code_i == KEY_HALF_HR) begin
              d0 = d0 + HALF_HR_STEP;
            end
            // At 99 minutes the seconds tens digit saturates instead of carrying.
            if (d2 > SEC_TENS_MAX) begin
              if (d0 == DIGIT_MAX && d1 == DIGIT_MAX) begin
                d2   = SEC_TENS_MAX;
                hold = 1'b1;
              end else begin
                d2 = 4'd0;
                d1 = d1 + 4'd1;
              end
            end
            if (!hold && d1 > DIGIT_MAX) begin
              if (d0 == DIGIT_MAX) begin
                d1             = DIGIT_MAX;
                flags_o.capped = 1'b1;
                hold           = 1'b1;
              end else begin
                d1 = 4'd0;
                d0 = d0 + 4'd1;
              end
            end
            if (!hold) begin
              if (d0 > DIGIT_MAX) begin
                d0 = DIGIT_MAX;
              end
              if ((|{d0, d1, d2, d3}) && cur_i.phase == PH_SETTING) begin
                nxt_o.phase = PH_ARMED;
              end
            end
          end
          flags_o.maxed = (d0 == DIGIT_MAX) && (d1 == DIGIT_MAX) && (d2 == SEC_TENS_MAX);
        end
      end
      FUNC_START_REL: begin
        if (cur_i.phase == PH_ARMED || cur_i.phase == PH_RUNNING) begin
          nxt_o.phase = PH_RUNNING;
        end
      end
      FUNC_STOP_REL: begin
        if (cur_i.phase == PH_ARMED || cur_i.phase == PH_RUNNING) begin
          nxt_o.phase = PH_ARMED;
        end
      end
      FUNC_STOP_HOLD: begin
        if (cur_i.phase == PH_ARMED || cur_i.phase == PH_RUNNING) begin
          d0             = 4'd0;
          d1             = 4'd0;
          d2             = 4'd0;
          d3             = 4'd0;
          nxt_o.cook_on  = 1'b0;
          nxt_o.grill_on = 1'b0;
          nxt_o.phase    = PH_SELECT;
        end
      end
      FUNC_TICK: begin
        if (cur_i.phase == PH_RUNNING) begin
          if (cur_nonzero) begin
            if (d3 == 4'd0) begin
              d3 = DIGIT_MAX;
              if (d2 == 4'd0) begin
                d2 = SEC_TENS_WRAP;
                if (d1 == 4'd0) begin
                  d1 = DIGIT_MAX;
                  d0 = d0 - 4'd1;
                end else begin
                  d1 = d1 - 4'd1;
                end
              end else begin
                d2 = d2 - 4'd1;
              end
            end else begin
              d3 = d3 - 4'd1;
            end
          end
          if (!(|{d0, d1, d2, d3})) begin
            flags_o.done   = 1'b1;
            nxt_o.cook_on  = 1'b0;
            nxt_o.grill_on = 1'b0;
            nxt_o.phase    = PH_SELECT;
          end
        end
      end
      default: begin
      end
    endcase

    nxt_o.min_tens = d0;
    nxt_o.min_ones = d1;
    nxt_o.sec_tens = d2[2:0];
    nxt_o.sec_ones = d3;
  end

endmodule

/* test/cooking_timer_checker.sv */
module cooking_timer_checker import ctc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] func_i,
  input  logic [7:0] key_code_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [3:0] minute_tens_i,
  input  logic [3:0] minute_ones_i,
  input  logic [2:0] second_tens_i,
  input  logic [3:0] second_ones_i,
  input  logic [1:0] phase_now_i,
  input  logic       cook_lamp_i,
  input  logic       grill_indicator_i,
  input  logic       done_pulse_i,
  input  logic       minutes_capped_i,
  input  logic       max_reached_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    timer_state_t st;
    step_flags_t  fl;
  } timer_result_t;

  // Digit order: minute tens, minute ones, second tens, second ones.
  logic [3:0]    digit [4];
  phase_e        phase;
  logic          cook_on;
  logic          grill_on;
  timer_result_t timer_results_q [$];
  int            mismatches = 0;

  function automatic bit timer_at_zero();
    return (digit[0] | digit[1] | digit[2] | digit[3]) == '0;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  // Applies one event to the predicted timer and returns the result it gives.
  function automatic timer_result_t advance_timer(input logic [2:0] f, input logic [7:0] k);
    timer_result_t r;
    logic          halt;
    logic          mode_key;
    r        = '0;
    halt     = 1'b0;
    mode_key = (k == KEY_MICRO_LO) || (k == KEY_MICRO_UP) ||
               (k == KEY_GRILL_LO) || (k == KEY_GRILL_UP);
    case (f)
      FUNC_KEY: begin
        // The receiver is off while running, so such keys change nothing.
        if (phase != PH_RUNNING) begin
          if (phase == PH_SELECT) begin
            if (k == KEY_MICRO_LO || k == KEY_MICRO_UP) begin
              cook_on = 1'b1;
              phase   = PH_SETTING;
            end else if (k == KEY_GRILL_LO || k == KEY_GRILL_UP) begin
              grill_on = 1'b1;
              phase    = PH_SETTING;
            end
          end else if (!mode_key) begin
            if (k == KEY_TEN_SEC)      digit[2] = digit[2] + 4'd1;
            else if (k == KEY_ONE_MIN) digit[1] = digit[1] + 4'd1;
            else if (k == KEY_HALF_HR) digit[0] = digit[0] + HALF_HR_STEP;
            if (digit[2] > SEC_TENS_MAX) begin
              if (digit[0] == DIGIT_MAX && digit[1] == DIGIT_MAX) begin
                digit[2] = SEC_TENS_MAX;
                halt     = 1'b1;
              end else begin
                digit[2] = '0;
                digit[1] = digit[1] + 4'd1;
              end
            end
            if (!halt && digit[1] > DIGIT_MAX) begin
              if (digit[0] == DIGIT_MAX) begin
                digit[1]    = DIGIT_MAX;
                r.fl.capped = 1'b1;
                halt        = 1'b1;
              end else begin
                digit[1] = '0;
                digit[0] = digit[0] + 4'd1;
              end
            end
            // A saturated entry skips the clamp and the button enable.
            if (!halt) begin
              if (digit[0] > DIGIT_MAX) digit[0] = DIGIT_MAX;
              if (!timer_at_zero() && phase == PH_SETTING) phase = PH_ARMED;
            end
          end
          r.fl.maxed = (digit[0] == DIGIT_MAX) && (digit[1] == DIGIT_MAX) &&
                       (digit[2] == SEC_TENS_MAX);
        end
      end
      FUNC_START_REL: if (phase == PH_ARMED || phase == PH_RUNNING) phase = PH_RUNNING;
      FUNC_STOP_REL:  if (phase == PH_ARMED || phase == PH_RUNNING) phase = PH_ARMED;
      FUNC_STOP_HOLD: begin
        if (phase == PH_ARMED || phase == PH_RUNNING) begin
          foreach (digit[i]) digit[i] = '0;
          cook_on  = 1'b0;
          grill_on = 1'b0;
          phase    = PH_SELECT;
        end
      end
      FUNC_TICK: begin
        if (phase == PH_RUNNING) begin
          if (!timer_at_zero()) begin
            if (digit[3] == '0) begin
              digit[3] = DIGIT_MAX;
              if (digit[2] == '0) begin
                digit[2] = SEC_TENS_WRAP;
                if (digit[1] == '0) begin
                  digit[1] = DIGIT_MAX;
                  digit[0] = digit[0] - 4'd1;
                end else begin
                  digit[1] = digit[1] - 4'd1;
                end
              end else begin
                digit[2] = digit[2] - 4'd1;
              end
            end else begin
              digit[3] = digit[3] - 4'd1;
            end
          end
          if (timer_at_zero()) begin
            r.fl.done = 1'b1;
            cook_on   = 1'b0;
            grill_on  = 1'b0;
            phase     = PH_SELECT;
          end
        end
      end
      default: ;
    endcase
    r.st.min_tens = digit[0];
    r.st.min_ones = digit[1];
    r.st.sec_tens = digit[2][2:0];
    r.st.sec_ones = digit[3];
    r.st.phase    = phase;
    r.st.cook_on  = cook_on;
    r.st.grill_on = grill_on;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t want;
    if (!rst_ni) begin
      foreach (digit[i]) digit[i] = '0;
      phase    = PH_SELECT;
      cook_on  = 1'b0;
      grill_on = 1'b0;
      timer_results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (timer_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result transfer with no event outstanding", $realtime);
        end else begin
          want = timer_results_q.pop_front();
          check_field("minute_tens", want.st.min_tens, minute_tens_i);
          check_field("minute_ones", want.st.min_ones, minute_ones_i);
          check_field("second_tens", want.st.sec_tens, second_tens_i);
          check_field("second_ones", want.st.sec_ones, second_ones_i);
          check_field("phase_now", int'(want.st.phase), phase_now_i);
          check_field("cook_lamp", want.st.cook_on, cook_lamp_i);
          check_field("grill_indicator", want.st.grill_on, grill_indicator_i);
          check_field("done_pulse", want.fl.done, done_pulse_i);
          check_field("minutes_capped", want.fl.capped, minutes_capped_i);
          check_field("max_reached", want.fl.maxed, max_reached_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        timer_results_q.push_back(advance_timer(func_i, key_code_i));
    end
    fail_count_o = mismatches;
    pending_o    = timer_results_q.size();
  end

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctc_pkg::*;

  localparam int         RANDOM_ITEMS  = 1800;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         IDLE_PERCENT  = 36;
  localparam int         CALM_FIRST    = 600;
  localparam int         CALM_LAST     = 900;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [7:0] KEY_OTHER     = 8'h78;
  localparam logic [7:0] KEY_HIGH_BIT  = 8'h80;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] func = '0;
  logic [7:0] key_code = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] minute_tens;
  logic [3:0] minute_ones;
  logic [2:0] second_tens;
  logic [3:0] second_ones;
  logic [1:0] phase_now;
  logic       cook_lamp;
  logic       grill_indicator;
  logic       done_pulse;
  logic       minutes_capped;
  logic       max_reached;
  int         fail_count;
  int         pending;
  bit         calm = 1'b0;
  int         events_sent = 0;
  int         random_first;
  int         cycles = 0;
  int         pick;

  always #5 clk = ~clk;

  cooking_timer_controller dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .func_i            (func),
    .key_code_i        (key_code),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .minute_tens_o     (minute_tens),
    .minute_ones_o     (minute_ones),
    .second_tens_o     (second_tens),
    .second_ones_o     (second_ones),
    .phase_now_o       (phase_now),
    .cook_lamp_o       (cook_lamp),
    .grill_indicator_o (grill_indicator),
    .done_pulse_o      (done_pulse),
    .minutes_capped_o  (minutes_capped),
    .max_reached_o     (max_reached)
  );

  cooking_timer_checker result_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .func_i            (func),
    .key_code_i        (key_code),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .minute_tens_i     (minute_tens),
    .minute_ones_i     (minute_ones),
    .second_tens_i     (second_tens),
    .second_ones_i     (second_ones),
    .phase_now_i       (phase_now),
    .cook_lamp_i       (cook_lamp),
    .grill_indicator_i (grill_indicator),
    .done_pulse_i      (done_pulse),
    .minutes_capped_i  (minutes_capped),
    .max_reached_i     (max_reached),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_event(input logic [2:0] f, input logic [7:0] k);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    key_code <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    events_sent++;
  endtask

  function automatic logic [7:0] pick_mode_key();
    case ($urandom_range(3))
      0:       return KEY_MICRO_LO;
      1:       return KEY_MICRO_UP;
      2:       return KEY_GRILL_LO;
      default: return KEY_GRILL_UP;
    endcase
  endfunction

  // Any byte except the three digit keys, so that the set time stays known.
  function automatic logic [7:0] non_digit_key();
    logic [7:0] k;
    k = 8'($urandom());
    if (k == KEY_TEN_SEC || k == KEY_ONE_MIN || k == KEY_HALF_HR) k ^= KEY_HIGH_BIT;
    return k;
  endfunction

  // Select a mode, set a short time, start and count it down, with pauses,
  // stray keys and the odd abort on the way. The tick count may overshoot
  // the real time slightly; surplus ticks land in select and are ignored.
  task automatic run_cook_cycle();
    int secs;
    int r;
    send_event(FUNC_KEY, pick_mode_key());
    if ($urandom_range(4) == 0) send_event(FUNC_START_REL, 8'($urandom()));
    secs = 0;
    repeat ($urandom_range(3, 1)) begin
      r = $urandom_range(9);
      if (r < 6) begin
        send_event(FUNC_KEY, KEY_TEN_SEC);
        secs += 10;
      end else if (r < 8) begin
        send_event(FUNC_KEY, KEY_ONE_MIN);
        secs += 60;
      end else begin
        send_event(FUNC_KEY, non_digit_key());
      end
    end
    send_event(FUNC_START_REL, 8'($urandom()));
    while (secs > 0) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_event(FUNC_TICK, 8'($urandom()));
        secs--;
      end else if (r < 84) begin
        send_event(FUNC_KEY, 8'($urandom()));
      end else if (r < 87) begin
        send_event(FUNC_START_REL, 8'($urandom()));
      end else if (r < 93) begin
        send_event(FUNC_STOP_REL, 8'($urandom()));
        if ($urandom_range(1) == 1) begin
          send_event(FUNC_KEY, KEY_TEN_SEC);
          secs += 10;
        end
        if ($urandom_range(1) == 1) send_event(FUNC_TICK, 8'($urandom()));
        send_event(FUNC_START_REL, 8'($urandom()));
      end else if (r < 95) begin
        send_event(FUNC_STOP_HOLD, 8'($urandom()));
        secs = 0;
      end else begin
        send_event(3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)), 8'($urandom()));
      end
    end
  endtask

  // Long digit entry that drives the time into both saturation limits.
  task automatic fill_to_cap();
    int r;
    send_event(FUNC_KEY, pick_mode_key());
    repeat ($urandom_range(60, 30)) begin
      r = $urandom_range(9);
      if (r < 2)      send_event(FUNC_KEY, KEY_HALF_HR);
      else if (r < 6) send_event(FUNC_KEY, KEY_ONE_MIN);
      else if (r < 9) send_event(FUNC_KEY, KEY_TEN_SEC);
      else            send_event(FUNC_KEY, non_digit_key());
    end
    if ($urandom_range(1) == 1) begin
      send_event(FUNC_START_REL, 8'($urandom()));
      repeat ($urandom_range(5, 1)) send_event(FUNC_TICK, 8'($urandom()));
      send_event(FUNC_STOP_REL, 8'($urandom()));
      repeat (3) send_event(FUNC_KEY, KEY_TEN_SEC);
    end
    send_event(FUNC_STOP_HOLD, 8'($urandom()));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(6, 1))
      send_event(3'($urandom_range(FUNC_SPARE_HI)), 8'($urandom()));
    send_event(FUNC_STOP_HOLD, 8'($urandom()));
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Events with no effect in select, then entry up to both limits, a short run and an abort.
    send_event(FUNC_KEY, KEY_OTHER);
    send_event(FUNC_SPARE_HI, KEY_MICRO_LO);
    send_event(FUNC_TICK, '0);
    send_event(FUNC_KEY, KEY_MICRO_UP);
    send_event(FUNC_START_REL, '1);
    send_event(FUNC_KEY, KEY_GRILL_LO);
    repeat (4) send_event(FUNC_KEY, KEY_HALF_HR);
    repeat (6) send_event(FUNC_KEY, KEY_TEN_SEC);
    repeat (10) send_event(FUNC_KEY, KEY_ONE_MIN);
    send_event(FUNC_KEY, KEY_TEN_SEC);
    send_event(FUNC_START_REL, KEY_OTHER);
    send_event(FUNC_TICK, KEY_OTHER);
    send_event(FUNC_STOP_REL, KEY_OTHER);
    send_event(FUNC_KEY, KEY_TEN_SEC);
    send_event(FUNC_STOP_HOLD, KEY_OTHER);

    random_first = events_sent;
    while (events_sent - random_first < RANDOM_ITEMS) begin
      calm = (events_sent - random_first >= CALM_FIRST) &&
             (events_sent - random_first < CALM_LAST);
      pick = $urandom_range(99);
      if (pick < 60)      run_cook_cycle();
      else if (pick < 75) fill_to_cap();
      else                send_noise();
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/ctc_pkg.sv
src/ctc_step.sv
src/cooking_timer_controller.sv
test/cooking_timer_checker.sv
test/testbench.sv
